// ===== sv/fbsc_pkg.sv =====
// ============================================================================
// fbsc_pkg
// Shared types and constants for the FAT boot sector check pipeline.
// ============================================================================
package fbsc_pkg;

    localparam int TOT_W  = 32;   // total sector count
    localparam int BPS_W  = 16;   // bytes per sector
    localparam int SPC_W  = 8;    // sectors per cluster
    localparam int RSV_W  = 16;   // reserved sectors
    localparam int FA_W   = 24;   // FAT copies times sectors per FAT
    localparam int CB_W   = 24;   // cluster size in bytes
    localparam int TB_W   = 48;   // volume size in bytes
    localparam int RNUM_W = 22;   // rounded-up root directory byte count
    localparam int RDS_W  = 21;   // root directory sectors
    localparam int FDS_W  = 25;   // first data sector

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_MEDIA   = 2'd2,
        ST_FAT32   = 2'd3
    } t_status;

    // Boot sector signature values
    localparam logic [7:0]  JMP_SHORT    = 8'hEB;
    localparam logic [7:0]  JMP_NOP      = 8'h90;
    localparam logic [7:0]  JMP_NEAR     = 8'hE9;
    localparam logic [7:0]  JMP_ALT      = 8'h69;
    localparam logic [7:0]  MEDIA_MASK   = 8'hF0;
    localparam logic [15:0] SECTOR_SIZE  = 16'd512;
    localparam logic [7:0]  MAX_SPC      = 8'd128;
    localparam logic [31:0] FAT12_LIMIT  = 32'd4085;
    localparam logic [31:0] FAT16_LIMIT  = 32'd65525;
    localparam int          DIR_ENT_SH   = 5;      // 32 bytes per entry

    // Decoded boot sector fields as they arrive
    typedef struct packed {
        logic [31:0] ts32;
        logic [15:0] ts16;
        logic [15:0] nroot;
        logic [15:0] spf;
        logic [7:0]  nfat;
        logic [15:0] rsv;
        logic [7:0]  spc;
        logic [15:0] bps;
        logic [7:0]  media;
        logic [7:0]  j2;
        logic [7:0]  j0;
    } t_boot;

    // Working record carried down the pipe; later fields fill in as it goes
    typedef struct packed {
        logic              invalid;
        logic              trusted;
        logic [TOT_W-1:0]  tot;
        logic [BPS_W-1:0]  bps;
        logic [SPC_W-1:0]  spc;
        logic [RSV_W-1:0]  rsv;
        logic [FA_W-1:0]   fat_area;
        logic [CB_W-1:0]   cbytes;
        logic [TB_W-1:0]   tbytes;
        logic [RNUM_W-1:0] rnum;
        logic [RDS_W-1:0]  rds;
        logic [FDS_W-1:0]  fds;
        logic [TOT_W-1:0]  dsc;
    } t_item;

endpackage

// ===== sv/fbsc_front.sv =====
// ============================================================================
// fbsc_front
// First stage: total count choice, products, signature checks.
// ============================================================================
module fbsc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  fbsc_pkg::t_boot i_boot,
    output logic           o_valid,
    input  logic           i_ready,
    output fbsc_pkg::t_item o_item
);
    import fbsc_pkg::*;

    logic  r_v;
    t_item r_item;
    t_item n_item;
    logic  w_en;
    logic  w_jmp;
    logic  w_pow2;

    assign w_en    = !r_v || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_v;
    assign o_item  = r_item;

    // Geometry products and trust flags
    always_comb begin
        n_item = '0;
        n_item.tot = (i_boot.ts16 != '0) ? TOT_W'(i_boot.ts16) : i_boot.ts32;
        n_item.invalid = (n_item.tot == '0) || (i_boot.bps == '0) || (i_boot.spc == '0);
        n_item.bps      = i_boot.bps;
        n_item.spc      = i_boot.spc;
        n_item.rsv      = i_boot.rsv;
        n_item.cbytes   = CB_W'(i_boot.bps) * CB_W'(i_boot.spc);
        n_item.tbytes   = TB_W'(i_boot.bps) * TB_W'(n_item.tot);
        n_item.fat_area = FA_W'(i_boot.nfat) * FA_W'(i_boot.spf);
        n_item.rnum     = (RNUM_W'(i_boot.nroot) << DIR_ENT_SH)
                        + RNUM_W'(i_boot.bps - 16'd1);
        w_jmp  = (i_boot.j0 == JMP_SHORT && i_boot.j2 == JMP_NOP)
              || i_boot.j0 == JMP_NEAR || i_boot.j0 == JMP_ALT;
        w_pow2 = (i_boot.spc & (i_boot.spc - 8'd1)) == 8'd0;
        n_item.trusted = w_jmp && ((i_boot.media & MEDIA_MASK) == MEDIA_MASK)
                      && (i_boot.bps == SECTOR_SIZE) && (i_boot.spc <= MAX_SPC) && w_pow2;
    end

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_en) begin
            r_v <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== sv/fbsc_div.sv =====
// ============================================================================
// fbsc_div
// Pipelined restoring divider, STEP quotient bits per stage, with sideband.
// ============================================================================
module fbsc_div #(
    parameter int NUM_W  = 22,
    parameter int DEN_W  = 16,
    parameter int STEP   = 4,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [NUM_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);
    localparam int NSTG = (NUM_W + STEP - 1) / STEP;
    localparam int NPAD = NSTG * STEP;

    logic              r_v    [NSTG];
    logic [DEN_W-1:0]  r_rem  [NSTG];
    logic [NPAD-1:0]   r_nq   [NSTG];
    logic [DEN_W-1:0]  r_den  [NSTG];
    logic [SIDE_W-1:0] r_side [NSTG];
    logic              w_en   [NSTG];
    logic              w_dn   [NSTG];
    logic              w_v_in [NSTG];
    logic [DEN_W-1:0]  w_den_in  [NSTG];
    logic [SIDE_W-1:0] w_side_in [NSTG];
    logic [DEN_W+NPAD-1:0] w_res [NSTG];

    // STEP shift-subtract steps; numerator shifts out, quotient shifts in
    function automatic logic [DEN_W+NPAD-1:0] step_f(
        input logic [DEN_W-1:0] rem_in,
        input logic [NPAD-1:0]  nq_in,
        input logic [DEN_W-1:0] den
    );
        logic [DEN_W:0]   t;
        logic [DEN_W-1:0] rem;
        logic [NPAD-1:0]  nq;
        rem = rem_in;
        nq  = nq_in;
        for (int s = 0; s < STEP; s++) begin
            t  = {rem, nq[NPAD-1]};
            nq = {nq[NPAD-2:0], 1'b0};
            if (t >= {1'b0, den}) begin
                t     = t - {1'b0, den};
                nq[0] = 1'b1;
            end
            rem = t[DEN_W-1:0];
        end
        return {rem, nq};
    endfunction

    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        // Stage inputs
        if (k == 0) begin : g_first
            assign w_v_in[k]    = i_valid;
            assign w_den_in[k]  = i_den;
            assign w_side_in[k] = i_side;
            assign w_res[k]     = step_f('0, NPAD'(i_num), i_den);
        end else begin : g_next
            assign w_v_in[k]    = r_v[k-1];
            assign w_den_in[k]  = r_den[k-1];
            assign w_side_in[k] = r_side[k-1];
            assign w_res[k]     = step_f(r_rem[k-1], r_nq[k-1], r_den[k-1]);
        end

        // Downstream readiness
        if (k == NSTG - 1) begin : g_last
            assign w_dn[k] = i_ready;
        end else begin : g_mid
            assign w_dn[k] = w_en[k+1];
        end
        assign w_en[k] = !r_v[k] || w_dn[k];

        // Valid flag
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_v[k] <= w_v_in[k];
            end
        end

        // Payload
        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                r_rem[k]  <= w_res[k][DEN_W+NPAD-1:NPAD];
                r_nq[k]   <= w_res[k][NPAD-1:0];
                r_den[k]  <= w_den_in[k];
                r_side[k] <= w_side_in[k];
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[NSTG-1];
    assign o_quo   = r_nq[NSTG-1][NUM_W-1:0];
    assign o_side  = r_side[NSTG-1];

endmodule

// ===== sv/fbsc_tail.sv =====
// ============================================================================
// fbsc_tail
// Middle stage: first data sector and saturated data sector count.
// ============================================================================
module fbsc_tail (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  fbsc_pkg::t_item         i_item,
    input  logic [fbsc_pkg::RNUM_W-1:0] i_rds,
    output logic                    o_valid,
    input  logic                    i_ready,
    output fbsc_pkg::t_item         o_item
);
    import fbsc_pkg::*;

    logic  r_v;
    t_item r_item;
    t_item n_item;
    logic  w_en;

    assign w_en    = !r_v || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_v;
    assign o_item  = r_item;

    // Area sum, then floor the remainder at zero
    always_comb begin
        n_item     = i_item;
        n_item.rds = i_rds[RDS_W-1:0];
        n_item.fds = FDS_W'(i_item.rsv) + FDS_W'(i_item.fat_area) + FDS_W'(n_item.rds);
        n_item.dsc = (i_item.tot > TOT_W'(n_item.fds)) ? (i_item.tot - TOT_W'(n_item.fds))
                                                     : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== sv/fat_boot_sector_check.sv =====
// ============================================================================
// fat_boot_sector_check
// FAT12/FAT16 boot sector parameter check and geometry derivation.
// ============================================================================
//
//  Port group   Dir  Payload
//  i_s_*        in   tdata: boot sector fields (152 bits)
//  o_m_*        out  tdata: geometry (216 bits), tuser: status, FAT16 flag
//
//  One item per cycle sustained while the output does not stall; the path
//  holds the front stage, six stages of the root directory divider, the
//  area stage, eight stages of the cluster count divider and the output register.
//  Reset (synchronous, active low) clears only the stage valid bits.
//  Each stage moves on when it is empty or its successor moves, so a
//  stall at the output fills bubbles first and loses no item.
//
module fat_boot_sector_check (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // j0[7:0] j2[15:8] media[23:16] sector_bytes[39:24] cluster_sectors[47:40]
    // reserved[63:48] fat_copies[71:64] fat_sectors[87:72] root_entries[103:88]
    // total_short[119:104] total_long[151:120]
    input  logic [151:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // total_sectors[31:0] cluster_bytes[55:32] total_bytes[103:56]
    // root_dir_sectors[124:104] data_sectors[156:125] cluster_count[188:157]
    // first_data_sector[213:189], zero fill [215:214]
    output logic [215:0] o_m_tdata,
    // status[1:0] fat_is_16[2]
    output logic [2:0]   o_m_tuser
);
    import fbsc_pkg::*;

    localparam int ITEM_W = $bits(t_item);

    t_boot             w_boot;
    logic              w_f_v, w_f_rdy;
    t_item             w_f_item;
    logic              w_d1_v, w_d1_rdy;
    logic [RNUM_W-1:0] w_d1_quo;
    logic [ITEM_W-1:0] w_d1_side;
    logic              w_t_v, w_t_rdy;
    t_item             w_t_item;
    logic              w_d2_v, w_d2_rdy;
    logic [TOT_W-1:0]  w_d2_quo;
    logic [ITEM_W-1:0] w_d2_side;
    t_item             w_fin;
    logic              w_out_en;

    logic              r_out_v;
    t_status           r_status;
    logic              r_fat16;
    logic [215:0]      r_data;
    t_status           n_status;
    logic              n_fat16;
    logic [215:0]      n_data;

    assign w_boot = t_boot'(i_s_tdata);

    fbsc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_boot  (w_boot),
        .o_valid (w_f_v),
        .i_ready (w_f_rdy),
        .o_item  (w_f_item)
    );

    // Root directory sectors: rounded byte count over sector size
    fbsc_div #(
        .NUM_W  (RNUM_W),
        .DEN_W  (BPS_W),
        .STEP   (4),
        .SIDE_W (ITEM_W)
    ) u_div_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_v),
        .o_ready (w_f_rdy),
        .i_num   (w_f_item.rnum),
        .i_den   (w_f_item.bps),
        .i_side  (w_f_item),
        .o_valid (w_d1_v),
        .i_ready (w_d1_rdy),
        .o_quo   (w_d1_quo),
        .o_side  (w_d1_side)
    );

    fbsc_tail u_tail (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_d1_v),
        .o_ready (w_d1_rdy),
        .i_item  (t_item'(w_d1_side)),
        .i_rds   (w_d1_quo),
        .o_valid (w_t_v),
        .i_ready (w_t_rdy),
        .o_item  (w_t_item)
    );

    // Cluster count: data sectors over sectors per cluster
    fbsc_div #(
        .NUM_W  (TOT_W),
        .DEN_W  (SPC_W),
        .STEP   (4),
        .SIDE_W (ITEM_W)
    ) u_div_clus (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_t_v),
        .o_ready (w_t_rdy),
        .i_num   (w_t_item.dsc),
        .i_den   (w_t_item.spc),
        .i_side  (w_t_item),
        .o_valid (w_d2_v),
        .i_ready (w_d2_rdy),
        .o_quo   (w_d2_quo),
        .o_side  (w_d2_side)
    );

    assign w_fin    = t_item'(w_d2_side);
    assign w_out_en = !r_out_v || i_m_tready;
    assign w_d2_rdy = w_out_en;

    // Status and result packing
    always_comb begin
        n_data = '0;
        n_data[31:0] = w_fin.tot;
        n_fat16 = 1'b0;
        if (w_fin.invalid) begin
            n_status = ST_INVALID;
        end else begin
            n_data[55:32]   = w_fin.cbytes;
            n_data[103:56]  = w_fin.tbytes;
            n_data[124:104] = w_fin.rds;
            n_data[156:125] = w_fin.dsc;
            n_data[188:157] = w_d2_quo;
            n_data[213:189] = w_fin.fds;
            priority if (!w_fin.trusted) begin
                n_status = ST_MEDIA;
            end else if (w_d2_quo < FAT12_LIMIT) begin
                n_status = ST_OK;
            end else if (w_d2_quo < FAT16_LIMIT) begin
                n_status = ST_OK;
                n_fat16  = 1'b1;
            end else begin
                n_status = ST_FAT32;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_en) begin
            r_out_v <= w_d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_en) begin
            r_status <= n_status;
            r_fat16  <= n_fat16;
            r_data   <= n_data;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_data;
    assign o_m_tuser  = {r_fat16, r_status};

    // An invalid volume carries only the total sector count
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_status == ST_INVALID) |-> (r_data[215:32] == '0 && !r_fat16))
        else $error("invalid volume with geometry");

    // FAT16 flag only with a good status and a count in the FAT16 range
    a_fat16_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_fat16) |-> (r_status == ST_OK && r_data[188:157] >= FAT12_LIMIT
                                  && r_data[188:157] < FAT16_LIMIT))
        else $error("FAT16 flag out of range");

    // FAT12 verdict needs a small count
    a_fat12_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_status == ST_OK && !r_fat16) |-> (r_data[188:157] < FAT12_LIMIT))
        else $error("FAT12 verdict with large count");

    // FAT32 verdict needs a large count
    a_fat32_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_status == ST_FAT32) |-> (r_data[188:157] >= FAT16_LIMIT))
        else $error("FAT32 verdict with small count");

    // Data sectors never exceed the total
    a_data_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_data[156:125] <= r_data[31:0]))
        else $error("data sectors above total");

endmodule

// ===== tb/fat_boot_sector_check_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fat_boot_sector_check_test
// Stream test of the FAT boot sector check: directed boot records, then
// random ones, with every result checked field by field against a predictor.
// ============================================================================
module fat_boot_sector_check_test;
    import fbsc_pkg::*;

    localparam int N_RANDOM = 1880;

    // Expected geometry and status of one boot record
    typedef struct packed {
        t_status     status;
        logic        is16;
        logic [31:0] tot;
        logic [23:0] cbytes;
        logic [47:0] tbytes;
        logic [20:0] rds;
        logic [31:0] dsc;
        logic [31:0] ccnt;
        logic [24:0] fds;
    } t_geom;

    // Directed row: record, plus a typed-in result where one applies
    typedef struct {
        t_boot   rec;
        logic    fixed;
        t_status st;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [151:0] i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [215:0] o_m_tdata;
    logic [2:0]   o_m_tuser;

    t_geom  geom_q[$];
    int     n_err = 0;
    int     sink_wait = 0;
    logic   sink_run = 1'b0;

    fat_boot_sector_check DUT (.*);

    always #2 i_clk = ~i_clk;

    // Derive the geometry a correct block reports for one record
    function automatic t_geom derive_geom(t_boot b);
        t_geom       g;
        logic [63:0] tot, bps, spc, rds, fds, dsc, ccnt;
        logic        jmp_ok, media_ok, clus_ok;
        g = '0;
        tot = (b.ts16 != 0) ? 64'(b.ts16) : 64'(b.ts32);
        g.tot = tot[31:0];
        bps = 64'(b.bps);
        spc = 64'(b.spc);
        if (tot == 0 || bps == 0 || spc == 0) begin
            g.status = ST_INVALID;
            return g;
        end
        rds = (64'(b.nroot) * 32 + bps - 1) / bps;
        fds = 64'(b.rsv) + 64'(b.nfat) * 64'(b.spf) + rds;
        dsc = (tot > fds) ? tot - fds : 64'd0;
        ccnt = dsc / spc;
        g.cbytes = 24'(bps * spc);
        g.tbytes = 48'(bps * tot);
        g.rds = 21'(rds);
        g.fds = 25'(fds);
        g.dsc = dsc[31:0];
        g.ccnt = ccnt[31:0];
        jmp_ok = (b.j0 == JMP_SHORT && b.j2 == JMP_NOP) || b.j0 == JMP_NEAR
            || b.j0 == JMP_ALT;
        media_ok = (b.media & MEDIA_MASK) == MEDIA_MASK;
        clus_ok = b.spc <= MAX_SPC && (b.spc & (b.spc - 8'd1)) == 0;
        if (!jmp_ok || !media_ok || bps != 512 || !clus_ok) begin
            g.status = ST_MEDIA;
        end else if (ccnt < 4085) begin
            g.status = ST_OK;
        end else if (ccnt < 65525) begin
            g.status = ST_OK;
            g.is16 = 1'b1;
        end else begin
            g.status = ST_FAT32;
        end
        return g;
    endfunction

    // A plausible boot record with random content
    function automatic t_boot sane_boot();
        t_boot b;
        b = 152'({$urandom, $urandom, $urandom, $urandom, $urandom});
        case ($urandom_range(2))
            0: begin b.j0 = JMP_SHORT; b.j2 = JMP_NOP; end
            1: b.j0 = JMP_NEAR;
            default: b.j0 = JMP_ALT;
        endcase
        b.media = {4'hF, b.media[3:0]};
        b.bps = 16'd512;
        b.spc = 8'd1 << $urandom_range(7);
        b.rsv = 16'($urandom_range(64));
        b.nfat = 8'($urandom_range(4));
        b.spf = 16'($urandom_range(300));
        b.nroot = 16'($urandom_range(1024));
        case ($urandom_range(3))
            0: begin b.ts16 = 16'($urandom_range(65535)); end
            1: begin b.ts16 = '0; b.ts32 = $urandom_range(3000000); end
            2: begin b.ts16 = '0; b.ts32 = $urandom_range(40000000); end
            default: begin b.ts16 = '0; end
        endcase
        return b;
    endfunction

    // Send one record after a gap; tvalid stays high between items with no gap
    task automatic send_boot(t_boot b, int gap);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= 152'(b);
        geom_q.push_back(derive_geom(b));
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Result side: random stalls, compare with oldest expectation
    always @(posedge i_clk) begin
        t_geom got, want;
        if (o_m_tvalid && i_m_tready) begin
            got = t_geom'({o_m_tuser[1:0], o_m_tuser[2], o_m_tdata[31:0],
                o_m_tdata[55:32], o_m_tdata[103:56], o_m_tdata[124:104],
                o_m_tdata[156:125], o_m_tdata[188:157], o_m_tdata[213:189]});
            if (geom_q.size() == 0) begin
                $display("%t unexpected result %h", $realtime, got);
                n_err++;
            end else begin
                want = geom_q.pop_front();
                if (got !== want || o_m_tdata[215:214] !== 2'b00) begin
                    $display("%t mismatch expected %h actual %h", $realtime, want, got);
                    n_err++;
                end
            end
        end
        // hold tready low for a drawn number of cycles before each item
        if (sink_run) begin
            if (o_m_tvalid && i_m_tready) begin
                sink_wait = $urandom_range(13);
                i_m_tready <= (sink_wait == 0);
            end else if (!i_m_tready) begin
                if (sink_wait > 0)
                    sink_wait--;
                i_m_tready <= (sink_wait == 0);
            end
        end
    end

    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        t_row  rows[$];
        t_boot b, base;
        t_geom g;
        int    wait_n;
        base = '0;
        base.j0 = JMP_SHORT; base.j2 = JMP_NOP; base.media = 8'hF8;
        base.bps = 16'd512; base.spc = 8'd4; base.rsv = 16'd1; base.nfat = 8'd2;
        base.spf = 16'd9; base.nroot = 16'd224; base.ts16 = 16'd2880;
        rows.push_back('{base, 1'b1, ST_OK});
        b = base; b.ts16 = 0; b.ts32 = 0; rows.push_back('{b, 1'b1, ST_INVALID});
        b = base; b.bps = 0; rows.push_back('{b, 1'b1, ST_INVALID});
        b = base; b.spc = 0; rows.push_back('{b, 1'b1, ST_INVALID});
        b = base; b.j0 = JMP_NEAR; b.j2 = 8'h00; rows.push_back('{b, 1'b1, ST_OK});
        b = base; b.j0 = JMP_ALT; rows.push_back('{b, 1'b1, ST_OK});
        b = base; b.j2 = 8'h91; rows.push_back('{b, 1'b1, ST_MEDIA});
        b = base; b.media = 8'hE8; rows.push_back('{b, 1'b1, ST_MEDIA});
        b = base; b.bps = 16'd1024; rows.push_back('{b, 1'b1, ST_MEDIA});
        b = base; b.spc = 8'd3; rows.push_back('{b, 1'b1, ST_MEDIA});
        b = base; b.spc = 8'd255; rows.push_back('{b, 1'b1, ST_MEDIA});
        b = base; b.spc = 8'd128; rows.push_back('{b, 1'b0, ST_OK});
        b = base; b.spc = 8'd1; b.ts16 = 0; b.ts32 = 32'd100000;
        rows.push_back('{b, 1'b0, ST_OK});
        b = base; b.spc = 8'd1; b.ts16 = 0; b.ts32 = 32'hFFFF_FFFF;
        rows.push_back('{b, 1'b1, ST_FAT32});
        b = base; b.ts16 = 16'd10; rows.push_back('{b, 1'b0, ST_OK});
        b = '1; rows.push_back('{b, 1'b0, ST_OK});
        b = '1; b.ts16 = 0; rows.push_back('{b, 1'b0, ST_OK});
        b = base; b.bps = 16'd1; b.nroot = 16'hFFFF; b.ts16 = 16'hFFFF;
        rows.push_back('{b, 1'b0, ST_OK});
        b = base; b.spc = 8'd1; b.spf = 16'hFFFF; b.nfat = 8'hFF; b.rsv = 16'hFFFF;
        b.ts16 = 0; b.ts32 = 32'hFFFF_FFFF; rows.push_back('{b, 1'b0, ST_OK});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sink_run <= 1'b1;
        foreach (rows[k]) begin
            g = derive_geom(rows[k].rec);
            if (rows[k].fixed && g.status != rows[k].st) begin
                $display("%t row %0d expected status %0d actual %0d", $realtime, k,
                    rows[k].st, g.status);
                n_err++;
            end
            send_boot(rows[k].rec, $urandom_range(13));
        end
        // hold the sender until the pipe has drained
        i_s_tvalid <= 1'b0;
        wait (geom_q.size() == 0);
        for (int k = 0; k < N_RANDOM; k++) begin
            if ($urandom_range(4) == 0)
                b = 152'({$urandom, $urandom, $urandom, $urandom, $urandom});
            else
                b = sane_boot();
            if (k % 300 < 40) begin
                // back-to-back stretch with no sender gap
                send_boot(b, 0);
            end else begin
                send_boot(b, $urandom_range(13));
            end
        end
        i_s_tvalid <= 1'b0;
        wait_n = 0;
        while (geom_q.size() != 0 && wait_n < 200000) begin
            @(posedge i_clk);
            wait_n++;
        end
        repeat (40) @(posedge i_clk);
        if (n_err == 0 && geom_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/fbsc_pkg.sv
sv/fbsc_front.sv
sv/fbsc_div.sv
sv/fbsc_tail.sv
sv/fat_boot_sector_check.sv
tb/fat_boot_sector_check_test.sv
